### hdl/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared constants and types for the HSV to RGB conversion pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package hsv2rgb_pkg;

  localparam int HUE_W   = 16;
  localparam int PCT_W   = 16;
  localparam int CHAN_W  = 8;

  // Hue in 1/64 degree, percent in 1/128 percent
  localparam int HUE_FULL   = 23040;
  localparam int HUE_SECTOR = 3840;
  localparam int PCT_FULL   = 12800;
  localparam int CHAN_MAX   = 255;

  localparam int HUE_REG_W  = 15;   // 0..23039
  localparam int PCT_REG_W  = 14;   // 0..12800
  localparam int TRI_W      = 12;   // 0..3840
  localparam int K_W        = 26;   // up to 12800*3840
  localparam int P_W        = K_W + PCT_REG_W;
  localparam int Y_W        = 18;   // 17*P >> 26, at most 159375
  localparam int RECIP_W    = 18;
  localparam int PROD_W     = Y_W + RECIP_W;

  // floor(y / 625) == (y * RECIP_625) >> RECIP_SHIFT for y < 2^18
  localparam int RECIP_625   = 214749;
  localparam int RECIP_SHIFT = 27;
  localparam int Y_SHIFT     = 26;

  localparam logic [K_W-1:0] K_FULL = K_W'(PCT_FULL * HUE_SECTOR);

  typedef enum logic [2:0] {
    SEC_0 = 3'd0,
    SEC_1 = 3'd1,
    SEC_2 = 3'd2,
    SEC_3 = 3'd3,
    SEC_4 = 3'd4,
    SEC_5 = 3'd5
  } sector_t;

  // Which term a channel carries on top of the offset
  typedef enum logic [1:0] {
    COMP_C = 2'd0,
    COMP_X = 2'd1,
    COMP_Z = 2'd2
  } comp_t;

  typedef struct packed {
    comp_t red;
    comp_t green;
    comp_t blue;
  } comp_sel_t;

endpackage

`default_nettype wire

### hdl/hsv_to_rgb_converter_core.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_core
// Pipelined HSV to 8-bit RGB conversion, one color per clock unless stalled.
// ----------------------------------------------------------------------------
// Input beat: hue (signed, 1/64 degree, wrapped into [0, 360)), saturation and
// brightness (signed, 1/128 percent, clamped to 0..100). Output beat: red,
// green and blue, 0..255, truncated.
// Both channels use valid/stall; a beat moves when valid is high and stall
// is low.
// Throughput: one beat per cycle unless stalled; the pipeline is eight register
// stages (wrap/clamp, sector, s*t product, term select, v*K product, scale by
// 17, reciprocal multiply, saturate) that all advance together.
// When the downstream side stalls while a result is waiting, the whole
// pipeline holds and in_stall is raised the same cycle; nothing is dropped
// or repeated.
// Reset (rst, synchronous) clears all valid bits; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_converter_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic signed [hsv2rgb_pkg::HUE_W-1:0] hue,
  input  wire logic signed [hsv2rgb_pkg::PCT_W-1:0] saturation,
  input  wire logic signed [hsv2rgb_pkg::PCT_W-1:0] brightness,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [hsv2rgb_pkg::CHAN_W-1:0]            red,
  output logic [hsv2rgb_pkg::CHAN_W-1:0]            green,
  output logic [hsv2rgb_pkg::CHAN_W-1:0]            blue
);

  localparam int HW = hsv2rgb_pkg::HUE_REG_W;
  localparam int PW = hsv2rgb_pkg::PCT_REG_W;
  localparam int TW = hsv2rgb_pkg::TRI_W;
  localparam int KW = hsv2rgb_pkg::K_W;
  localparam int XW = hsv2rgb_pkg::P_W;
  localparam int YW = hsv2rgb_pkg::Y_W;
  localparam int MW = hsv2rgb_pkg::PROD_W;

  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Stage valid bits
  logic s0_valid, s1_valid, s2_valid, s3_valid, s4_valid, s5_valid, s6_valid;

  // ---------------- stage 0: wrap hue, clamp percentages
  logic signed [16:0] hue_ext;
  logic signed [16:0] hue_wrap;
  logic [HW-1:0] s0_hue;
  logic [PW-1:0] s0_sat, s0_val;

  function automatic logic [PW-1:0] clamp_pct(input logic signed [hsv2rgb_pkg::PCT_W-1:0] x);
    logic [PW-1:0] r;
    if (x < 0) r = '0;
    else if (x > hsv2rgb_pkg::PCT_FULL) r = PW'(hsv2rgb_pkg::PCT_FULL);
    else r = x[PW-1:0];
    return r;
  endfunction

  always_comb begin
    hue_ext = 17'(hue);
    if (hue_ext < -17'sd23040) hue_wrap = hue_ext + 17'sd46080;
    else if (hue_ext < 0) hue_wrap = hue_ext + 17'sd23040;
    else if (hue_ext >= 17'sd23040) hue_wrap = hue_ext - 17'sd23040;
    else hue_wrap = hue_ext;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_hue <= hue_wrap[HW-1:0];
      s0_sat <= clamp_pct(saturation);
      s0_val <= clamp_pct(brightness);
    end
  end

  // ---------------- stage 1: sector and triangle term
  hsv2rgb_pkg::sector_t sector_next;
  logic [HW-1:0] hue_base;
  logic [TW:0]   tri_p;
  logic [TW-1:0] tri_next;
  hsv2rgb_pkg::sector_t s1_sector;
  logic [TW-1:0] s1_tri;
  logic [PW-1:0] s1_sat, s1_val;

  always_comb begin
    if (s0_hue < HW'(1 * hsv2rgb_pkg::HUE_SECTOR)) sector_next = hsv2rgb_pkg::SEC_0;
    else if (s0_hue < HW'(2 * hsv2rgb_pkg::HUE_SECTOR)) sector_next = hsv2rgb_pkg::SEC_1;
    else if (s0_hue < HW'(3 * hsv2rgb_pkg::HUE_SECTOR)) sector_next = hsv2rgb_pkg::SEC_2;
    else if (s0_hue < HW'(4 * hsv2rgb_pkg::HUE_SECTOR)) sector_next = hsv2rgb_pkg::SEC_3;
    else if (s0_hue < HW'(5 * hsv2rgb_pkg::HUE_SECTOR)) sector_next = hsv2rgb_pkg::SEC_4;
    else sector_next = hsv2rgb_pkg::SEC_5;

    // hue modulo two sectors
    if (s0_hue < HW'(2 * hsv2rgb_pkg::HUE_SECTOR)) hue_base = '0;
    else if (s0_hue < HW'(4 * hsv2rgb_pkg::HUE_SECTOR))
      hue_base = HW'(2 * hsv2rgb_pkg::HUE_SECTOR);
    else hue_base = HW'(4 * hsv2rgb_pkg::HUE_SECTOR);
    tri_p = (TW + 1)'(s0_hue - hue_base);

    if (tri_p >= (TW + 1)'(hsv2rgb_pkg::HUE_SECTOR))
      tri_next = TW'(tri_p - (TW + 1)'(hsv2rgb_pkg::HUE_SECTOR));
    else
      tri_next = TW'((TW + 1)'(hsv2rgb_pkg::HUE_SECTOR) - tri_p);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sector <= sector_next;
      s1_tri    <= tri_next;
      s1_sat    <= s0_sat;
      s1_val    <= s0_val;
    end
  end

  // ---------------- stage 2: s*t product, complement of saturation
  hsv2rgb_pkg::sector_t s2_sector;
  logic [KW-1:0] s2_st;
  logic [PW-1:0] s2_satinv, s2_val;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_sector <= s1_sector;
      s2_st     <= KW'(s1_sat) * KW'(s1_tri);
      s2_satinv <= PW'(hsv2rgb_pkg::PCT_FULL) - s1_sat;
      s2_val    <= s1_val;
    end
  end

  // ---------------- stage 3: per-channel term K, channel = 255*v*K/D
  hsv2rgb_pkg::comp_sel_t comp_sel;
  logic [KW-1:0] k_x, k_z;
  logic [KW-1:0] s3_k_red, s3_k_green, s3_k_blue;
  logic [PW-1:0] s3_val;

  always_comb begin
    case (s2_sector)
      hsv2rgb_pkg::SEC_0: comp_sel = '{hsv2rgb_pkg::COMP_C, hsv2rgb_pkg::COMP_X,
                                       hsv2rgb_pkg::COMP_Z};
      hsv2rgb_pkg::SEC_1: comp_sel = '{hsv2rgb_pkg::COMP_X, hsv2rgb_pkg::COMP_C,
                                       hsv2rgb_pkg::COMP_Z};
      hsv2rgb_pkg::SEC_2: comp_sel = '{hsv2rgb_pkg::COMP_Z, hsv2rgb_pkg::COMP_C,
                                       hsv2rgb_pkg::COMP_X};
      hsv2rgb_pkg::SEC_3: comp_sel = '{hsv2rgb_pkg::COMP_Z, hsv2rgb_pkg::COMP_X,
                                       hsv2rgb_pkg::COMP_C};
      hsv2rgb_pkg::SEC_4: comp_sel = '{hsv2rgb_pkg::COMP_X, hsv2rgb_pkg::COMP_Z,
                                       hsv2rgb_pkg::COMP_C};
      default:            comp_sel = '{hsv2rgb_pkg::COMP_C, hsv2rgb_pkg::COMP_Z,
                                       hsv2rgb_pkg::COMP_X};
    endcase
    // X + M = v*(12800*3840 - s*t); 0 + M = v*3840*(12800 - s); C + M = v*12800*3840
    k_x = hsv2rgb_pkg::K_FULL - s2_st;
    k_z = KW'(s2_satinv) * KW'(hsv2rgb_pkg::HUE_SECTOR);
  end

  function automatic logic [KW-1:0] pick_k(input hsv2rgb_pkg::comp_t c,
                                          input logic [KW-1:0] kx,
                                          input logic [KW-1:0] kz);
    logic [KW-1:0] r;
    case (c)
      hsv2rgb_pkg::COMP_C: r = hsv2rgb_pkg::K_FULL;
      hsv2rgb_pkg::COMP_X: r = kx;
      default:             r = kz;
    endcase
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_k_red   <= pick_k(comp_sel.red,   k_x, k_z);
      s3_k_green <= pick_k(comp_sel.green, k_x, k_z);
      s3_k_blue  <= pick_k(comp_sel.blue,  k_x, k_z);
      s3_val     <= s2_val;
    end
  end

  // ---------------- stage 4: v*K
  logic [XW-1:0] s4_p_red, s4_p_green, s4_p_blue;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_p_red   <= XW'(s3_val) * XW'(s3_k_red);
      s4_p_green <= XW'(s3_val) * XW'(s3_k_green);
      s4_p_blue  <= XW'(s3_val) * XW'(s3_k_blue);
    end
  end

  // ---------------- stage 5: y = (17*P) >> 26, since 255/D = 17/(625*2^26)
  logic [XW+4:0] sum_red, sum_green, sum_blue;
  logic [YW-1:0] s5_y_red, s5_y_green, s5_y_blue;

  always_comb begin
    sum_red   = {s4_p_red,   4'b0} + (XW + 5)'(s4_p_red);
    sum_green = {s4_p_green, 4'b0} + (XW + 5)'(s4_p_green);
    sum_blue  = {s4_p_blue,  4'b0} + (XW + 5)'(s4_p_blue);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_y_red   <= sum_red[hsv2rgb_pkg::Y_SHIFT +: YW];
      s5_y_green <= sum_green[hsv2rgb_pkg::Y_SHIFT +: YW];
      s5_y_blue  <= sum_blue[hsv2rgb_pkg::Y_SHIFT +: YW];
    end
  end

  // ---------------- stage 6: divide by 625 through reciprocal
  logic [MW-1:0] s6_m_red, s6_m_green, s6_m_blue;

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_m_red   <= MW'(s5_y_red)   * MW'(hsv2rgb_pkg::RECIP_625);
      s6_m_green <= MW'(s5_y_green) * MW'(hsv2rgb_pkg::RECIP_625);
      s6_m_blue  <= MW'(s5_y_blue)  * MW'(hsv2rgb_pkg::RECIP_625);
    end
  end

  // ---------------- stage 7: quotient, saturate, output register
  localparam int QW = MW - hsv2rgb_pkg::RECIP_SHIFT;

  function automatic logic [hsv2rgb_pkg::CHAN_W-1:0] sat_chan(input logic [MW-1:0] m);
    logic [QW-1:0] q;
    logic [hsv2rgb_pkg::CHAN_W-1:0] r;
    q = m[MW-1:hsv2rgb_pkg::RECIP_SHIFT];
    if (q > QW'(hsv2rgb_pkg::CHAN_MAX)) r = hsv2rgb_pkg::CHAN_W'(hsv2rgb_pkg::CHAN_MAX);
    else r = q[hsv2rgb_pkg::CHAN_W-1:0];
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      red   <= sat_chan(s6_m_red);
      green <= sat_chan(s6_m_green);
      blue  <= sat_chan(s6_m_blue);
    end
  end

  // ---------------- valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid  <= 1'b0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      s5_valid  <= 1'b0;
      s6_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s0_valid  <= in_valid;
      s1_valid  <= s0_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      s5_valid  <= s4_valid;
      s6_valid  <= s5_valid;
      out_valid <= s6_valid;
    end
  end

  // ---------------- assertions
  a_range_s0: assert property (@(posedge clk) disable iff (rst)
    s0_valid |-> (s0_hue < HW'(hsv2rgb_pkg::HUE_FULL)) &&
                 (s0_sat <= PW'(hsv2rgb_pkg::PCT_FULL)) &&
                 (s0_val <= PW'(hsv2rgb_pkg::PCT_FULL)))
    else $error("wrap/clamp out of range");

  a_tri_range: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> s1_tri <= TW'(hsv2rgb_pkg::HUE_SECTOR))
    else $error("triangle term out of range");

  a_no_sat: assert property (@(posedge clk) disable iff (rst)
    s6_valid |-> s6_m_red[MW-1:hsv2rgb_pkg::RECIP_SHIFT] <= QW'(hsv2rgb_pkg::CHAN_MAX))
    else $error("red channel exceeded full scale");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    (adv && s6_valid) |=> out_valid)
    else $error("beat lost at output stage");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !s0_valid)
    else $error("valid bits not cleared by reset");

endmodule

`default_nettype wire

### test/hsv_to_rgb_checker.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_checker
// Watches both beat channels of the HSV to RGB core, predicts each color
// from the accepted input beat and compares it with the next output beat.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_checker
  import hsv2rgb_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  input  wire logic                     in_stall,
  input  wire logic signed [HUE_W-1:0]  hue,
  input  wire logic signed [PCT_W-1:0]  saturation,
  input  wire logic signed [PCT_W-1:0]  brightness,
  input  wire logic                     out_valid,
  input  wire logic                     out_stall,
  input  wire logic [CHAN_W-1:0]        red,
  input  wire logic [CHAN_W-1:0]        green,
  input  wire logic [CHAN_W-1:0]        blue,
  output int                            fail_count,
  output int                            pending_beats,
  output int                            colors_checked
);

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  rgb_t pending_rgb[$];
  int   errs    = 0;
  int   checked = 0;

  function automatic longint unsigned pct_clamp(input logic signed [PCT_W-1:0] p);
    if (p < 0) return 0;
    if (p > PCT_FULL) return PCT_FULL;
    return longint'(p);
  endfunction

  function automatic logic [CHAN_W-1:0] chan_scale(input longint unsigned num);
    longint unsigned den;
    longint unsigned q;
    den = longint'(PCT_FULL) * PCT_FULL * HUE_SECTOR;
    q   = (num * CHAN_MAX) / den;
    if (q > CHAN_MAX) q = CHAN_MAX;
    return CHAN_W'(q);
  endfunction

  // Exact rational math over the common denominator 12800*12800*3840
  function automatic rgb_t rgb_from_hsv(input logic signed [HUE_W-1:0] h_in,
                                        input logic signed [PCT_W-1:0] s_in,
                                        input logic signed [PCT_W-1:0] v_in);
    int              h_wrap;
    longint unsigned s, v, ph, tri_dist;
    longint unsigned c_term, x_term, m_term;
    longint unsigned r_n, g_n, b_n;
    sector_t         sec;
    rgb_t            px;
    h_wrap = int'(h_in) % HUE_FULL;
    if (h_wrap < 0) h_wrap += HUE_FULL;
    s  = pct_clamp(s_in);
    v  = pct_clamp(v_in);
    ph = longint'(h_wrap % (2 * HUE_SECTOR));
    tri_dist = (ph >= HUE_SECTOR) ? ph - HUE_SECTOR : HUE_SECTOR - ph;
    c_term = v * s * HUE_SECTOR;
    x_term = v * s * (HUE_SECTOR - tri_dist);
    m_term = v * PCT_FULL * HUE_SECTOR - c_term;
    sec = sector_t'(3'(h_wrap / HUE_SECTOR));
    case (sec)
      SEC_0: begin r_n = c_term; g_n = x_term; b_n = 0;      end
      SEC_1: begin r_n = x_term; g_n = c_term; b_n = 0;      end
      SEC_2: begin r_n = 0;      g_n = c_term; b_n = x_term; end
      SEC_3: begin r_n = 0;      g_n = x_term; b_n = c_term; end
      SEC_4: begin r_n = x_term; g_n = 0;      b_n = c_term; end
      default: begin r_n = c_term; g_n = 0;    b_n = x_term; end
    endcase
    px.red   = chan_scale(r_n + m_term);
    px.green = chan_scale(g_n + m_term);
    px.blue  = chan_scale(b_n + m_term);
    return px;
  endfunction

  always @(posedge clk) begin
    rgb_t want;
    if (!rst) begin
      if (in_valid && !in_stall)
        pending_rgb = {pending_rgb, rgb_from_hsv(hue, saturation, brightness)};
      if (out_valid && !out_stall) begin
        if (pending_rgb.size() == 0) begin
          $error("unexpected output beat: red %0d green %0d blue %0d", red, green, blue);
          errs++;
        end else begin
          want = pending_rgb.pop_front();
          checked++;
          if (red !== want.red) begin
            $error("red mismatch: expected %0d, got %0d", want.red, red);
            errs++;
          end
          if (green !== want.green) begin
            $error("green mismatch: expected %0d, got %0d", want.green, green);
            errs++;
          end
          if (blue !== want.blue) begin
            $error("blue mismatch: expected %0d, got %0d", want.blue, blue);
            errs++;
          end
        end
      end
    end
    fail_count     <= errs;
    pending_beats  <= pending_rgb.size();
    colors_checked <= checked;
  end

endmodule

`default_nettype wire

### test/tb_hsv_to_rgb_converter_core.sv
// ----------------------------------------------------------------------------
// tb_hsv_to_rgb_converter_core
// Drives directed corner colors and then random HSV beats in bursts into the
// converter while the output side stalls in shifting patterns; the checker
// beside the block predicts and compares every color.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_hsv_to_rgb_converter_core;
  import hsv2rgb_pkg::*;

  localparam int RANDOM_BEATS = 1800;
  localparam int DRAIN_CYCLES = 16;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic                     clk;
  logic                     rst        = 1'b1;
  logic                     in_valid   = 1'b0;
  logic                     in_stall;
  logic signed [HUE_W-1:0]  hue        = '0;
  logic signed [PCT_W-1:0]  saturation = '0;
  logic signed [PCT_W-1:0]  brightness = '0;
  logic                     out_valid;
  logic                     out_stall  = 1'b0;
  logic [CHAN_W-1:0]        red;
  logic [CHAN_W-1:0]        green;
  logic [CHAN_W-1:0]        blue;

  int fail_count;
  int pending_beats;
  int colors_checked;
  int beats_sent = 0;

  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left  = 0;

  hsv_to_rgb_converter_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .red        (red),
    .green      (green),
    .blue       (blue)
  );

  hsv_to_rgb_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .hue            (hue),
    .saturation     (saturation),
    .brightness     (brightness),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .red            (red),
    .green          (green),
    .blue           (blue),
    .fail_count     (fail_count),
    .pending_beats  (pending_beats),
    .colors_checked (colors_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

  // Receiver stall pattern switches between modes after each random-length stretch
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(20, 300);
      end
      mode_left--;
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
        default:     out_stall <= (mode_left % 3 == 0);
      endcase
    end
  end

  // Holds the beat until it is taken; leaves valid high for the next one
  task automatic send_beat(input int h, input int s, input int v);
    in_valid   <= 1'b1;
    hue        <= HUE_W'(h);
    saturation <= PCT_W'(s);
    brightness <= PCT_W'(v);
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  task automatic drain_colors();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_beats != 0);
  endtask

  function automatic int random_pct();
    case ($urandom_range(0, 9))
      7:       return -int'($urandom_range(1, 32768));
      8:       return int'($urandom_range(PCT_FULL + 1, 32767));
      9:       return int'($urandom_range(0, 65535)) - 32768;
      default: return int'($urandom_range(0, PCT_FULL));
    endcase
  endfunction

  initial begin
    int directed;
    int burst;
    int gap;
    int h;
    bit paused;
    paused = 1'b0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // sector starts, wrap edges, clamp edges
    send_beat(0,         PCT_FULL, PCT_FULL);
    send_beat(3840,      PCT_FULL, PCT_FULL);
    send_beat(7680,      PCT_FULL, PCT_FULL);
    send_beat(11520,     PCT_FULL, PCT_FULL);
    send_beat(15360,     PCT_FULL, PCT_FULL);
    send_beat(19200,     PCT_FULL, PCT_FULL);
    send_beat(3839,      PCT_FULL, PCT_FULL);
    send_beat(HUE_FULL-1, PCT_FULL, PCT_FULL);
    send_beat(HUE_FULL,  PCT_FULL, PCT_FULL);
    send_beat(-1,        PCT_FULL, PCT_FULL);
    send_beat(-32768,    6400,     9000);
    send_beat(32767,     PCT_FULL, PCT_FULL);
    send_beat(-HUE_FULL, PCT_FULL, PCT_FULL);
    send_beat(1920,      0,        PCT_FULL);
    send_beat(5000,      PCT_FULL, 0);
    send_beat(9000,      -1,       PCT_FULL);
    send_beat(9000,      -32768,   6400);
    send_beat(13000,     PCT_FULL + 1, PCT_FULL);
    send_beat(13000,     32767,    32767);
    send_beat(17000,     6400,     -1);
    send_beat(17000,     6400,     -32768);
    send_beat(21000,     PCT_FULL, PCT_FULL + 1);
    send_beat(1000,      1,        1);
    directed = beats_sent;
    drain_colors();

    while (beats_sent < directed + RANDOM_BEATS) begin
      burst = $urandom_range(1, 48);
      for (int i = 0; i < burst && beats_sent < directed + RANDOM_BEATS; i++) begin
        case ($urandom_range(0, 3))
          0: h = int'($urandom_range(0, 65535)) - 32768;
          1: h = int'($urandom_range(0, HUE_FULL - 1));
          2: h = int'($urandom_range(0, 6)) * HUE_SECTOR + int'($urandom_range(0, 4)) - 2;
          default: h = -int'($urandom_range(1, 32768));
        endcase
        send_beat(h, random_pct(), random_pct());
      end
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      if (!paused && beats_sent >= directed + RANDOM_BEATS / 2) begin
        drain_colors();
        paused = 1'b1;
      end
    end

    drain_colors();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d color beats (%0d directed corners, %0d random), checked %0d results",
             beats_sent, directed, beats_sent - directed, colors_checked);
    $display("Covered all hue sectors, hue wrap, clamped saturation and brightness, stalls");
    if (fail_count == 0 && pending_beats == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
